/* src/pimrp_pkg.sv */
// Package for the point-in-mesh ray parity block: widths, payload types,
// register indexes, the controller command bundle and small coordinate helpers.
// No dependencies.
package pimrp_pkg;

  localparam int COORD_BITS = 16;
  localparam int INDEX_BITS = 16;

  // Differences of two coordinates, cross terms, dot terms and their sum.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int PROD_W  = CROSS_W + DIFF_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Corner selectors inside the triangle a, b, c.
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic [INDEX_BITS-1:0]        vertex_index;
    logic                         last_vertex;
  } vertex_t;

  typedef struct packed {
    logic inside_res;
    logic on_surface;
  } result_t;

  typedef struct packed {
    logic       store;       // write the accepted vertex into a corner register
    logic       store_slot;
    logic       capture;     // hold the accepted vertex as corner c
    logic       load_diff;   // register b-a, c-a and p-a
    logic       opd_load;    // load the cross-unit operands
    logic       opd_nrm;     // operands for a normal component, else an edge test
    logic [1:0] ld_k;
    logic [1:0] ld_i;
    logic       n_wr;
    logic [1:0] n_k;
    logic       dot_en;
    logic [1:0] dot_step;
    logic       hit_init;
    logic       ev;
    logic [1:0] ev_k;
    logic [1:0] ev_i;
    logic       apply;
    logic       emit;
  } ctrl_cmd_t;

  function automatic logic [1:0] next_axis(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_Z;
      default: r = AXIS_X;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] coord_of(input vertex_t v,
                                                            input logic [1:0] k);
    logic signed [COORD_BITS-1:0] r;
    case (k)
      AXIS_X:  r = v.vertex_x;
      AXIS_Y:  r = v.vertex_y;
      default: r = v.vertex_z;
    endcase
    return r;
  endfunction

endpackage

/* src/point_in_mesh_ray_parity.sv */
// Point-in-mesh test by ray parity along both directions of x, y and z.
// A vertex that opens or continues a triangle is taken in the idle state. The
// third corner occupies the shared cross and dot units through the load,
// normal, dot, edge and apply states, and no vertex is taken meanwhile. The
// result is registered from the final state after a last triangle or a last
// vertex that closes no triangle, later while an earlier result waits.
// Synchronous reset clears the point, corner count and parities.
module point_in_mesh_ray_parity (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pimrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pimrp_pkg::COORD_BITS-1:0]  cfg_data,
  input  logic                              vtx_valid,
  output logic                              vtx_ready,
  input  pimrp_pkg::vertex_t                vtx,
  output logic                              res_valid,
  input  logic                              res_ready,
  output pimrp_pkg::result_t                res
);
  import pimrp_pkg::*;

  ctrl_cmd_t cmd;

  pimrp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .vtx_valid   (vtx_valid),
    .vtx_ready   (vtx_ready),
    .last_vertex (vtx.last_vertex),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .cmd         (cmd)
  );

  pimrp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx       (vtx),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

/* src/pimrp_ctrl.sv */
// Controller of the point-in-mesh ray parity block: corner counting, the
// triangle test sequence and the result hand-off. Depends on pimrp_pkg.
module pimrp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  vtx_valid,
  output logic                  vtx_ready,
  input  logic                  last_vertex,
  input  logic                  res_valid,
  input  logic                  res_ready,
  output pimrp_pkg::ctrl_cmd_t  cmd
);
  import pimrp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_NRM   = 3'd2;
  localparam logic [2:0] S_DOT   = 3'd3;
  localparam logic [2:0] S_EDGE  = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [3:0] NRM_LAST  = 4'd3;
  localparam logic [3:0] DOT_LAST  = 4'd3;
  localparam logic [3:0] EDGE_LAST = 4'd9;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [1:0] slot, slot_next;
  logic       last_r, last_r_next;
  logic [1:0] lk, lk_next, li, li_next;
  logic [1:0] ek, ei;
  logic       accept;

  assign vtx_ready = (state == S_IDLE);
  assign accept    = vtx_valid && vtx_ready;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt + 4'd1;
    slot_next   = slot;
    last_r_next = last_r;
    lk_next     = lk;
    li_next     = li;
    cmd         = '0;
    cmd.store_slot = slot[0];
    cmd.ld_k    = lk;
    cmd.ld_i    = li;
    cmd.ev_k    = ek;
    cmd.ev_i    = ei;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          cmd.capture = 1'b1;
          last_r_next = last_vertex;
          if (slot == 2'd2) begin
            slot_next  = '0;
            state_next = S_LOAD;
          end else begin
            cmd.store = 1'b1;
            slot_next = slot + 2'd1;
            if (last_vertex) begin
              slot_next  = '0;
              state_next = S_FIN;
            end
          end
        end
      end
      S_LOAD: begin
        cmd.load_diff = 1'b1;
        cnt_next      = '0;
        state_next    = S_NRM;
      end
      S_NRM: begin
        // Operands for component cnt go in while component cnt-1 is written.
        cmd.opd_load = (cnt != NRM_LAST);
        cmd.opd_nrm  = 1'b1;
        cmd.ld_k     = cnt[1:0];
        cmd.n_wr     = (cnt != 4'd0);
        cmd.n_k      = cnt[1:0] - 2'd1;
        if (cnt == NRM_LAST) begin
          cnt_next   = '0;
          state_next = S_DOT;
        end
      end
      S_DOT: begin
        cmd.dot_en   = 1'b1;
        cmd.dot_step = cnt[1:0];
        cmd.hit_init = (cnt == 4'd0);
        lk_next      = AXIS_X;
        li_next      = CORNER_A;
        if (cnt == DOT_LAST) begin
          cnt_next   = '0;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.opd_load = (cnt != EDGE_LAST);
        cmd.ev       = (cnt != 4'd0);
        if (li == CORNER_C) begin
          li_next = CORNER_A;
          lk_next = lk + 2'd1;
        end else begin
          li_next = li + 2'd1;
        end
        if (cnt == EDGE_LAST) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // A new result waits here until the result register is free.
        if (!res_valid || res_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      slot   <= '0;
      last_r <= 1'b0;
      lk     <= AXIS_X;
      li     <= CORNER_A;
      ek     <= AXIS_X;
      ei     <= CORNER_A;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      slot   <= slot_next;
      last_r <= last_r_next;
      lk     <= lk_next;
      li     <= li_next;
      ek     <= lk;
      ei     <= li;
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !vtx_ready)
    else $error("vertex taken while a triangle is in progress");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot != 2'd3)
    else $error("corner count out of range");

  a_third_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && slot == 2'd2) |=> (state == S_LOAD && slot == 2'd0))
    else $error("third corner did not start a triangle test");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && last_vertex && slot != 2'd2) |=> (state == S_FIN))
    else $error("last vertex did not lead to a result");

endmodule

/* src/pimrp_datapath.sv */
// Datapath of the point-in-mesh ray parity block: query point, corners, the
// shared cross-product and dot-product units, hit parity and result register.
// Depends on pimrp_pkg.
module pimrp_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pimrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pimrp_pkg::COORD_BITS-1:0]     cfg_data,
  input  pimrp_pkg::vertex_t                   vtx,
  input  pimrp_pkg::ctrl_cmd_t                 cmd,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output pimrp_pkg::result_t                   res
);
  import pimrp_pkg::*;

  logic signed [COORD_BITS-1:0] pt [3];
  vertex_t corner_a, corner_b, corner_c;

  logic signed [DIFF_W-1:0]  ab [3];
  logic signed [DIFF_W-1:0]  ac [3];
  logic signed [DIFF_W-1:0]  qa [3];
  logic signed [CROSS_W-1:0] nrm [3];

  logic signed [DIFF_W-1:0]  opa, opb, opc, opd;
  logic signed [DIFF_W-1:0]  opa_next, opb_next, opc_next, opd_next;
  logic signed [CROSS_W-1:0] ea, eb, ec, ed, xprod;

  logic signed [PROD_W-1:0] prod, mul_n, mul_q;
  logic signed [ACC_W-1:0]  acc;

  logic [2:0] hit;
  logic [5:0] parity;
  logic       surface;

  vertex_t    v0, v1, e0, e1;
  logic [1:0] u_ax, w_ax;
  logic signed [CROSS_W-1:0] n_ev;
  logic       cross_zero, cs_neg, reject;

  // Query point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pt[0] <= '0;
      pt[1] <= '0;
      pt[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_X: pt[0] <= cfg_data;
        REG_POINT_Y: pt[1] <= cfg_data;
        REG_POINT_Z: pt[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic vertex_t pick(input logic [1:0] i, input vertex_t a,
                                   input vertex_t b, input vertex_t c);
    vertex_t r;
    case (i)
      CORNER_A: r = a;
      CORNER_B: r = b;
      default:  r = c;
    endcase
    return r;
  endfunction

  // Operands of the shared cross unit: a*b - c*d.
  always_comb begin
    v0   = pick(cmd.ld_i, corner_a, corner_b, corner_c);
    v1   = pick(next_axis(cmd.ld_i), corner_a, corner_b, corner_c);
    u_ax = next_axis(cmd.ld_k);
    w_ax = next_axis(u_ax);
    if (cmd.opd_nrm) begin
      opa_next = ab[u_ax];
      opb_next = ac[w_ax];
      opc_next = ab[w_ax];
      opd_next = ac[u_ax];
    end else begin
      opa_next = DIFF_W'(coord_of(v1, u_ax)) - DIFF_W'(coord_of(v0, u_ax));
      opb_next = DIFF_W'(pt[w_ax]) - DIFF_W'(coord_of(v0, w_ax));
      opc_next = DIFF_W'(coord_of(v1, w_ax)) - DIFF_W'(coord_of(v0, w_ax));
      opd_next = DIFF_W'(pt[u_ax]) - DIFF_W'(coord_of(v0, u_ax));
    end
  end

  assign ea    = CROSS_W'(opa);
  assign eb    = CROSS_W'(opb);
  assign ec    = CROSS_W'(opc);
  assign ed    = CROSS_W'(opd);
  assign xprod = ea * eb - ec * ed;

  assign mul_n = PROD_W'(nrm[cmd.dot_step]);
  assign mul_q = PROD_W'(qa[cmd.dot_step]);

  // Edge-test verdict for the operands loaded in the previous cycle.
  always_comb begin
    e0         = pick(cmd.ev_i, corner_a, corner_b, corner_c);
    e1         = pick(next_axis(cmd.ev_i), corner_a, corner_b, corner_c);
    n_ev       = nrm[cmd.ev_k];
    cross_zero = (xprod == '0);
    cs_neg     = !cross_zero && (xprod[CROSS_W-1] ^ n_ev[CROSS_W-1]);
    reject     = cs_neg || (cross_zero && (e1.vertex_index > e0.vertex_index));
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (cmd.store_slot) corner_b <= vtx;
      else                corner_a <= vtx;
    end
    if (cmd.capture) corner_c <= vtx;
    if (cmd.load_diff) begin
      for (int j = 0; j < 3; j++) begin
        ab[j] <= DIFF_W'(coord_of(corner_b, 2'(j))) - DIFF_W'(coord_of(corner_a, 2'(j)));
        ac[j] <= DIFF_W'(coord_of(corner_c, 2'(j))) - DIFF_W'(coord_of(corner_a, 2'(j)));
        qa[j] <= DIFF_W'(pt[j]) - DIFF_W'(coord_of(corner_a, 2'(j)));
      end
    end
    if (cmd.opd_load) begin
      opa <= opa_next;
      opb <= opb_next;
      opc <= opc_next;
      opd <= opd_next;
    end
    if (cmd.n_wr) nrm[cmd.n_k] <= xprod;
    // Dot product n.(p-a): one product a cycle, summed in the next cycle.
    if (cmd.dot_en) begin
      prod <= mul_n * mul_q;
      if (cmd.dot_step == 2'd1) acc <= ACC_W'(prod);
      else if (cmd.dot_step != 2'd0) acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit       <= '0;
      parity    <= '0;
      surface   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.hit_init) begin
        for (int j = 0; j < 3; j++) hit[j] <= (nrm[j] != '0);
      end
      if (cmd.ev && reject) hit[cmd.ev_k] <= 1'b0;
      if (cmd.apply) begin
        // The hit lies before the point when n.(p-a) and n_k share a sign.
        for (int j = 0; j < 3; j++) begin
          if (hit[j]) begin
            if (acc == '0) surface <= 1'b1;
            else if (acc[ACC_W-1] == nrm[j][CROSS_W-1]) parity[2*j] <= ~parity[2*j];
            else parity[2*j+1] <= ~parity[2*j+1];
          end
        end
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
        parity    <= '0;
        surface   <= 1'b0;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.inside_res <= !surface && (parity == 6'h3F);
      res.on_surface <= surface;
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (res_valid && parity == '0 && !surface))
    else $error("result not presented or mesh state not cleared");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(cmd.apply || cmd.ev || cmd.dot_en))
    else $error("result taken while a triangle is still being tested");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed");

endmodule
